FILE: rtl/rgbhsv_pkg.sv
`default_nettype none

package rgbhsv_pkg;

	// Field and datapath widths
	localparam int CH_W      = 8;
	localparam int SAT_NUM_W = 16;   // 255 * spread
	localparam int HUE_NUM_W = 14;   // 43 * |diff|
	localparam int QUO_W     = 8;
	localparam int QIDX_W    = 3;
	localparam int DIV_STEPS = QUO_W;

	// Scale factors and hue sector offsets
	localparam logic [CH_W-1:0] SAT_SCALE  = 8'd255;
	localparam logic [5:0]      HUE_SCALE  = 6'd43;
	localparam logic [CH_W-1:0] OFF_RED    = 8'd0;
	localparam logic [CH_W-1:0] OFF_GREEN  = 8'd85;
	localparam logic [CH_W-1:0] OFF_BLUE   = 8'd171;

	// Hue sector codes
	localparam logic [1:0] SEC_RED   = 2'd0;
	localparam logic [1:0] SEC_GREEN = 2'd1;
	localparam logic [1:0] SEC_BLUE  = 2'd2;

	// One item in flight through the two divider lanes
	typedef struct packed {
		logic [SAT_NUM_W-1:0] sat_rem;
		logic [CH_W-1:0]      sat_den;
		logic [QUO_W-1:0]     sat_quo;
		logic [HUE_NUM_W-1:0] hue_rem;
		logic [CH_W-1:0]      hue_den;
		logic [QUO_W-1:0]     hue_quo;
		logic                 neg;
		logic [1:0]           sector;
		logic [CH_W-1:0]      bright;
	} div_lane_t;

	// One restoring step on both lanes: resolve quotient bit bitpos
	function automatic div_lane_t div_step(div_lane_t l, logic [QIDX_W-1:0] bitpos);
		logic [SAT_NUM_W-1:0] sd;
		logic [HUE_NUM_W:0]   hd;
		div_lane_t            n;
		n  = l;
		sd = {{(SAT_NUM_W-CH_W){1'b0}}, l.sat_den} << bitpos;
		hd = {{(HUE_NUM_W+1-CH_W){1'b0}}, l.hue_den} << bitpos;
		if (l.sat_rem >= sd) begin
			n.sat_rem         = l.sat_rem - sd;
			n.sat_quo[bitpos] = 1'b1;
		end
		if ({1'b0, l.hue_rem} >= hd) begin
			n.hue_rem         = HUE_NUM_W'({1'b0, l.hue_rem} - hd);
			n.hue_quo[bitpos] = 1'b1;
		end
		return n;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/rgbhsv_front.sv
`default_nettype none

module rgbhsv_front
	import rgbhsv_pkg::*;
(
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            adv,
	input  wire logic            pix_valid,
	input  wire logic [CH_W-1:0] red,
	input  wire logic [CH_W-1:0] green,
	input  wire logic [CH_W-1:0] blue,
	output logic                 lane_valid,
	output div_lane_t            lane
);

	logic [CH_W-1:0] mx, mn;
	logic [1:0]      sector;
	logic signed [CH_W:0] diff;

	logic                 valid_s1;
	logic [CH_W-1:0]      bright_s1;
	logic [CH_W-1:0]      low_s1;
	logic [1:0]           sector_s1;
	logic signed [CH_W:0] diff_s1;

	logic [CH_W-1:0]      spread;
	logic [CH_W-1:0]      mag;

	logic                 valid_s2;
	div_lane_t            lane_s2;

	// Find max, min, hue sector and channel difference; red wins ties, then green
	always_comb begin
		mx = (red > green) ? red : green;
		if (blue > mx) mx = blue;
		mn = (red < green) ? red : green;
		if (blue < mn) mn = blue;
		if (mx == red) begin
			sector = SEC_RED;
			diff   = $signed({1'b0, green}) - $signed({1'b0, blue});
		end else if (mx == green) begin
			sector = SEC_GREEN;
			diff   = $signed({1'b0, blue}) - $signed({1'b0, red});
		end else begin
			sector = SEC_BLUE;
			diff   = $signed({1'b0, red}) - $signed({1'b0, green});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= pix_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			bright_s1 <= mx;
			low_s1    <= mn;
			sector_s1 <= sector;
			diff_s1   <= diff;
		end
	end

	// Form both dividends and divisors
	always_comb begin
		spread = bright_s1 - low_s1;
		mag    = diff_s1[CH_W] ? CH_W'(-diff_s1) : diff_s1[CH_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			lane_s2.sat_rem <= {spread, {CH_W{1'b0}}} - {{CH_W{1'b0}}, spread};
			lane_s2.sat_den <= bright_s1;
			lane_s2.sat_quo <= '0;
			lane_s2.hue_rem <= {{(HUE_NUM_W-CH_W){1'b0}}, mag}
			                   * {{(HUE_NUM_W-6){1'b0}}, HUE_SCALE};
			lane_s2.hue_den <= spread;
			lane_s2.hue_quo <= '0;
			lane_s2.neg     <= diff_s1[CH_W];
			lane_s2.sector  <= sector_s1;
			lane_s2.bright  <= bright_s1;
		end
	end

	assign lane_valid = valid_s2;
	assign lane       = lane_s2;

endmodule

`default_nettype wire

FILE: rtl/rgbhsv_div.sv
`default_nettype none

module rgbhsv_div
	import rgbhsv_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      adv,
	input  wire logic      in_valid,
	input  wire div_lane_t in_lane,
	output logic           out_valid,
	output div_lane_t      out_lane
);

	div_lane_t lane_s  [DIV_STEPS];
	logic      vld_s   [DIV_STEPS];
	div_lane_t stage_in[DIV_STEPS];
	logic      vin     [DIV_STEPS];

	// One quotient bit per stage, most significant first
	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
		if (k == 0) begin : g_first
			assign stage_in[k] = in_lane;
			assign vin[k]      = in_valid;
		end else begin : g_next
			assign stage_in[k] = lane_s[k-1];
			assign vin[k]      = vld_s[k-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (adv) begin
				vld_s[k] <= vin[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				lane_s[k] <= div_step(stage_in[k], QIDX_W'(DIV_STEPS - 1 - k));
			end
		end
	end

	assign out_valid = vld_s[DIV_STEPS-1];
	assign out_lane  = lane_s[DIV_STEPS-1];

endmodule

`default_nettype wire

FILE: rtl/rgbhsv_back.sv
`default_nettype none

module rgbhsv_back
	import rgbhsv_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      adv,
	input  wire logic      in_valid,
	input  wire div_lane_t in_lane,
	output logic           hsv_valid,
	output logic [CH_W-1:0] hue,
	output logic [CH_W-1:0] saturation,
	output logic [CH_W-1:0] brightness
);

	logic [CH_W-1:0] sat;
	logic [CH_W-1:0] part;
	logic [CH_W-1:0] offset;
	logic [CH_W-1:0] hue_d;

	logic            valid_q;
	logic [CH_W-1:0] hue_q;
	logic [CH_W-1:0] sat_q;
	logic [CH_W-1:0] bright_q;

	// Force black and grey pixels, add the sector offset with wrap
	always_comb begin
		sat  = (in_lane.bright == '0) ? '0 : in_lane.sat_quo;
		part = in_lane.neg ? CH_W'(-in_lane.hue_quo) : in_lane.hue_quo;
		unique case (in_lane.sector)
			SEC_RED:   offset = OFF_RED;
			SEC_GREEN: offset = OFF_GREEN;
			default:   offset = OFF_BLUE;
		endcase
		hue_d = (sat == '0) ? '0 : offset + part;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hue_q    <= hue_d;
			sat_q    <= sat;
			bright_q <= in_lane.bright;
		end
	end

	assign hsv_valid  = valid_q;
	assign hue        = hue_q;
	assign saturation = sat_q;
	assign brightness = bright_q;

endmodule

`default_nettype wire

FILE: rtl/rgb_to_hsv_8bit.sv
// Integer RGB to HSV conversion for 8-bit pixels. One pixel enters per clock and
// one result leaves per clock, sustained while hsv_stall stays low; each pixel
// passes through two front stages (max/min and dividend forming), eight stages
// of a restoring divider that resolves one quotient bit per stage for saturation
// and hue side by side, and the output register. The pipeline advances as a whole:
// pix_stall rises only while a result sits in the output register with
// hsv_stall high, and then every stage holds its item.
`default_nettype none

module rgb_to_hsv_8bit
	import rgbhsv_pkg::*;
(
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            pix_valid,
	output logic                 pix_stall,
	input  wire logic [CH_W-1:0] red,
	input  wire logic [CH_W-1:0] green,
	input  wire logic [CH_W-1:0] blue,
	output logic                 hsv_valid,
	input  wire logic            hsv_stall,
	output logic [CH_W-1:0]      hue,
	output logic [CH_W-1:0]      saturation,
	output logic [CH_W-1:0]      brightness
);

	logic      adv;
	logic      front_valid;
	div_lane_t front_lane;
	logic      div_valid;
	div_lane_t div_lane;

	// Advance when the output register is empty or being taken
	assign adv       = !hsv_valid || !hsv_stall;
	assign pix_stall = !adv;

	rgbhsv_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.pix_valid (pix_valid),
		.red       (red),
		.green     (green),
		.blue      (blue),
		.lane_valid(front_valid),
		.lane      (front_lane)
	);

	rgbhsv_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (front_valid),
		.in_lane  (front_lane),
		.out_valid(div_valid),
		.out_lane (div_lane)
	);

	rgbhsv_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (div_valid),
		.in_lane   (div_lane),
		.hsv_valid (hsv_valid),
		.hue       (hue),
		.saturation(saturation),
		.brightness(brightness)
	);

	// Black pixel gives zero hue and saturation
	a_black: assert property (@(posedge clk) disable iff (!arst_n)
		hsv_valid && (brightness == '0) |-> (hue == '0) && (saturation == '0))
		else $error("black pixel with nonzero hue or saturation");

	// Grey pixel gives zero hue
	a_grey: assert property (@(posedge clk) disable iff (!arst_n)
		hsv_valid && (saturation == '0) |-> (hue == '0))
		else $error("grey pixel with nonzero hue");

	// Upstream is held only by a waiting result
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pix_stall |-> hsv_valid && hsv_stall)
		else $error("input stalled without a pending result");

endmodule

`default_nettype wire

FILE: test/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import rgbhsv_pkg::*;

	// One converted pixel as the block reports it
	typedef struct packed {
		logic [CH_W-1:0] hue;
		logic [CH_W-1:0] sat;
		logic [CH_W-1:0] bright;
	} hsv_t;

	localparam int IDLE_PCT    = 8;
	localparam int HOLDOFF_LEN = 400;

	logic            clk = 1'b0;
	logic            arst_n = 1'b0;
	logic            pix_valid = 1'b0;
	logic            pix_stall;
	logic [CH_W-1:0] red = '0;
	logic [CH_W-1:0] green = '0;
	logic [CH_W-1:0] blue = '0;
	logic            hsv_valid;
	logic            hsv_stall = 1'b0;
	logic [CH_W-1:0] hue;
	logic [CH_W-1:0] saturation;
	logic [CH_W-1:0] brightness;

	hsv_t hsv_expected[$];
	int   fail_count = 0;
	int   pixels_sent = 0;
	int   results_checked = 0;
	int   black_seen = 0;
	int   grey_seen = 0;
	int   neg_hue_seen = 0;
	int   holdoff_left = 0;
	bit   pix_gaps_on = 1'b1;
	bit   hsv_stalls_on = 1'b1;

	rgb_to_hsv_8bit u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.pix_valid  (pix_valid),
		.pix_stall  (pix_stall),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.hsv_valid  (hsv_valid),
		.hsv_stall  (hsv_stall),
		.hue        (hue),
		.saturation (saturation),
		.brightness (brightness)
	);

	always #5 clk = ~clk;

	// Predict hue, saturation and value for one pixel
	function automatic hsv_t predict_hsv(logic [CH_W-1:0] r, logic [CH_W-1:0] g,
			logic [CH_W-1:0] b);
		int   mx, mn, spread, sat, diff, mag, quo, offset;
		hsv_t res;
		mx = (r > g) ? r : g;
		if (b > mx) mx = b;
		mn = (r < g) ? r : g;
		if (b < mn) mn = b;
		res = '0;
		res.bright = mx[CH_W-1:0];
		if (mx == 0) return res;
		spread = mx - mn;
		sat = (255 * spread) / mx;
		res.sat = sat[CH_W-1:0];
		if (sat == 0) return res;
		// red beats green, green beats blue on a tied maximum
		if (mx == r) begin
			diff = int'(g) - int'(b);
			offset = OFF_RED;
		end else if (mx == g) begin
			diff = int'(b) - int'(r);
			offset = OFF_GREEN;
		end else begin
			diff = int'(r) - int'(g);
			offset = OFF_BLUE;
		end
		mag = (diff < 0) ? -diff : diff;
		quo = (43 * mag) / spread;
		offset = (diff < 0) ? offset - quo : offset + quo;
		res.hue = offset[CH_W-1:0];
		return res;
	endfunction

	// Pick a random pixel, biased toward greys, ties, tiny spreads and extremes
	function automatic logic [3*CH_W-1:0] random_pixel();
		logic [CH_W-1:0] r, g, b, top;
		int              kind;
		kind = $urandom_range(0, 9);
		r = CH_W'($urandom);
		g = CH_W'($urandom);
		b = CH_W'($urandom);
		case (kind)
			0: begin
				g = r;
				b = r;
			end
			1: begin
				top = (r > g) ? r : g;
				case ($urandom_range(0, 2))
					0: begin r = top; g = top; end
					1: begin g = top; b = top; end
					default: begin r = top; b = top; end
				endcase
			end
			2: begin
				r = r & 8'h03;
				g = g & 8'h03;
				b = b & 8'h03;
			end
			3: begin
				r = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
				g = ($urandom_range(0, 1) != 0) ? 8'hFF - (g & 8'h01) : (g & 8'h01);
				b = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
			end
			default: ;
		endcase
		return {r, g, b};
	endfunction

	// Offer one item, wait for it to be taken, record the expected result
	task automatic send_pixel(input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
			input logic [CH_W-1:0] b);
		hsv_t exp_res;
		while (pix_gaps_on && $urandom_range(0, 99) < IDLE_PCT) begin
			pix_valid = 1'b0;
			@(negedge clk);
		end
		pix_valid = 1'b1;
		red = r;
		green = g;
		blue = b;
		do @(posedge clk); while (pix_stall);
		exp_res = predict_hsv(r, g, b);
		hsv_expected.push_back(exp_res);
		pixels_sent++;
		if (exp_res.bright == 0) black_seen++;
		else if (exp_res.sat == 0) grey_seen++;
		@(negedge clk);
		pix_valid = 1'b0;
	endtask

	task automatic wait_drained();
		while (hsv_expected.size() != 0) @(negedge clk);
	endtask

	// Corners of the ranges, every hue sector, ties and wrapping hues
	task automatic test_directed();
		send_pixel(8'd0, 8'd0, 8'd0);
		send_pixel(8'd255, 8'd255, 8'd255);
		send_pixel(8'd1, 8'd1, 8'd1);
		send_pixel(8'd255, 8'd0, 8'd0);
		send_pixel(8'd0, 8'd255, 8'd0);
		send_pixel(8'd0, 8'd0, 8'd255);
		send_pixel(8'd1, 8'd0, 8'd0);
		send_pixel(8'd0, 8'd0, 8'd1);
		send_pixel(8'd255, 8'd255, 8'd0);
		send_pixel(8'd0, 8'd255, 8'd255);
		send_pixel(8'd255, 8'd0, 8'd255);
		send_pixel(8'd200, 8'd200, 8'd200);
		send_pixel(8'd255, 8'd254, 8'd254);
		send_pixel(8'd1, 8'd1, 8'd0);
		send_pixel(8'd200, 8'd10, 8'd100);
		send_pixel(8'd100, 8'd200, 8'd0);
		send_pixel(8'd0, 8'd100, 8'd200);
		send_pixel(8'd255, 8'd0, 8'd1);
		send_pixel(8'd128, 8'd127, 8'd0);
		send_pixel(8'd170, 8'd85, 8'd170);
		send_pixel(8'd85, 8'd170, 8'd170);
		send_pixel(8'd254, 8'd1, 8'd128);
		wait_drained();
	endtask

	// Back-to-back items with neither side idling
	task automatic test_full_rate(input int count);
		logic [3*CH_W-1:0] pix;
		pix_gaps_on = 1'b0;
		hsv_stalls_on = 1'b0;
		repeat (count) begin
			pix = random_pixel();
			send_pixel(pix[23:16], pix[15:8], pix[7:0]);
		end
		pix_gaps_on = 1'b1;
		hsv_stalls_on = 1'b1;
	endtask

	// Random items with random gaps and stalls on both sides
	task automatic test_random(input int count);
		logic [3*CH_W-1:0] pix;
		repeat (count) begin
			pix = random_pixel();
			send_pixel(pix[23:16], pix[15:8], pix[7:0]);
		end
	endtask

	// Hold off the output long enough that the pipeline fills and stalls its input
	task automatic test_output_holdoff(input int count);
		logic [3*CH_W-1:0] pix;
		holdoff_left = HOLDOFF_LEN;
		repeat (count) begin
			pix = random_pixel();
			send_pixel(pix[23:16], pix[15:8], pix[7:0]);
		end
	endtask

	// Pause input until every pending result is out, then resume
	task automatic test_drain_pause(input int count);
		logic [3*CH_W-1:0] pix;
		repeat (count) begin
			pix = random_pixel();
			send_pixel(pix[23:16], pix[15:8], pix[7:0]);
		end
		wait_drained();
		repeat (count) begin
			pix = random_pixel();
			send_pixel(pix[23:16], pix[15:8], pix[7:0]);
		end
	endtask

	// Drive output stall: long hold-off, otherwise random stalls
	always @(negedge clk) begin
		if (holdoff_left > 0) begin
			hsv_stall = 1'b1;
			holdoff_left = holdoff_left - 1;
		end else if (!hsv_stalls_on) begin
			hsv_stall = 1'b0;
		end else begin
			hsv_stall = ($urandom_range(0, 99) < IDLE_PCT);
		end
	end

	// Compare each accepted result with the oldest expectation
	always @(posedge clk) begin
		hsv_t exp_res;
		if (arst_n && hsv_valid && !hsv_stall) begin
			if (hsv_expected.size() == 0) begin
				$error("result with nothing expected: hue %0d sat %0d value %0d",
					hue, saturation, brightness);
				fail_count++;
			end else begin
				exp_res = hsv_expected.pop_front();
				results_checked++;
				if (hue != exp_res.hue) begin
					$error("hue: expected %0d, got %0d", exp_res.hue, hue);
					fail_count++;
				end
				if (saturation != exp_res.sat) begin
					$error("saturation: expected %0d, got %0d", exp_res.sat, saturation);
					fail_count++;
				end
				if (brightness != exp_res.bright) begin
					$error("brightness: expected %0d, got %0d", exp_res.bright, brightness);
					fail_count++;
				end
				if (exp_res.hue > 8'd213 && exp_res.sat != 0) neg_hue_seen++;
			end
		end
	end

	initial begin
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_full_rate(400);
		test_random(1000);
		test_output_holdoff(150);
		test_drain_pause(60);
		test_random(400);
		wait_drained();
		repeat (30) @(negedge clk);
		$display("Sent %0d pixels, checked %0d results (%0d black, %0d grey, %0d wrapped hues),",
			pixels_sent, results_checked, black_seen, grey_seen, neg_hue_seen);
		$display("with full-rate, random-gap, long output hold-off and drain-pause phases.");
		if (fail_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	// Stop a hung run
	initial begin
		#4ms;
		$display("timeout with %0d results still pending", hsv_expected.size());
		$display("*** FAILED ***");
		$finish;
	end

endmodule

FILE: files.f
rtl/rgbhsv_pkg.sv
rtl/rgbhsv_front.sv
rtl/rgbhsv_div.sv
rtl/rgbhsv_back.sv
rtl/rgb_to_hsv_8bit.sv
test/testbench.sv
